>>> design/etd_pkg.sv
// Shared types, constants and small arithmetic functions of the event time decoder.
package etd_pkg;

  localparam int unsigned STAGES = 11;

  localparam logic [15:0] MJD_MIN      = 16'd15079;
  localparam logic [22:0] X_OFFSET     = 23'd1507820;     // 15078.2 scaled by 100
  localparam logic [22:0] YEAR_DIV     = 23'd36525;       // 365.25 scaled by 100
  localparam logic [16:0] YEAR_RECIP   = 17'd117589;      // floor(2^32 / 36525)
  localparam logic [23:0] HUND_RECIP   = 24'd10737419;    // ceil(2^30 / 100)
  localparam logic [29:0] M_OFFSET     = 30'd149561000;   // 14956.1 scaled by 10000
  localparam logic [22:0] MONTH_DIV    = 23'd306001;      // 30.6001 scaled by 10000
  localparam logic [13:0] MONTH_RECIP  = 14'd14035;       // floor(2^32 / 306001)
  localparam logic [17:0] SEVEN_RECIP  = 18'd149797;      // ceil(2^20 / 7)
  localparam logic [15:0] DAY_OFFSET   = 16'd14956;
  localparam logic [39:0] START_UNDEF  = 40'hFF_FFFF_FFFF;
  localparam logic [23:0] DUR_UNDEF    = 24'hFF_FFFF;

  typedef struct packed {
    logic [39:0] st_code;
    logic [23:0] du_code;
    logic        st_undef;
    logic        du_undef;
    logic [15:0] mjd_raw;
    logic [15:0] mjd;
    logic [22:0] x;
    logic [16:0] wdv;
    logic [13:0] wq;
    logic [2:0]  week_day;
    logic [7:0]  h;
    logic [7:0]  m;
    logic [7:0]  s;
    logic [7:0]  dh;
    logic [7:0]  dm;
    logic [7:0]  ds;
    logic [19:0] dsec;
    logic [7:0]  yp_est;
    logic [7:0]  yp;
    logic [22:0] y;
    logic [15:0] ip;
    logic [22:0] n;
    logic [3:0]  mp_est;
    logic [3:0]  mp;
    logic [4:0]  day;
    logic [7:0]  year;
    logic [3:0]  mon;
    logic [8:0]  es_sum;
    logic [5:0]  es;
    logic [2:0]  cs;
    logic [8:0]  em_sum;
    logic [5:0]  em;
    logic [2:0]  cm;
    logic [8:0]  eh_sum;
    logic [4:0]  eh;
    logic [3:0]  ch;
    logic [4:0]  eday;
    logic [3:0]  emon;
    logic [7:0]  eyear;
  } etd_pipe_t;

  function automatic logic [7:0] bcd_byte(input logic [7:0] b);
    return 8'(b[7:4]) * 8'd10 + 8'(b[3:0]);
  endfunction

  // {carry, remainder} of a sum below 360 split by 60
  function automatic logic [8:0] div60(input logic [8:0] v);
    logic [2:0] c;
    c = '0;
    for (int k = 1; k <= 5; k++) begin
      if (v >= 9'(60 * k)) c = 3'(k);
    end
    return {c, 6'(v - 9'(c) * 9'd60)};
  endfunction

  // {carry, remainder} of a sum below 336 split by 24
  function automatic logic [8:0] div24(input logic [8:0] v);
    logic [3:0] c;
    c = '0;
    for (int k = 1; k <= 13; k++) begin
      if (v >= 9'(24 * k)) c = 4'(k);
    end
    return {c, 5'(v - 9'(c) * 9'd24)};
  endfunction

  // floor(mp * 30.6001)
  function automatic logic [8:0] month_days(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:  r = 9'd0;
      4'd1:  r = 9'd30;
      4'd2:  r = 9'd61;
      4'd3:  r = 9'd91;
      4'd4:  r = 9'd122;
      4'd5:  r = 9'd153;
      4'd6:  r = 9'd183;
      4'd7:  r = 9'd214;
      4'd8:  r = 9'd244;
      4'd9:  r = 9'd275;
      4'd10: r = 9'd306;
      4'd11: r = 9'd336;
      4'd12: r = 9'd367;
      4'd13: r = 9'd397;
      4'd14: r = 9'd428;
      default: r = 9'd459;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic [7:0] yr);
    logic leap;
    logic [4:0] r;
    leap = (yr[1:0] == 2'b00) && (yr != 8'd0) && (yr != 8'd200);
    unique case (mon)
      4'd1:                      r = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

>>> design/etd_core.sv
// Arithmetic pipeline: MJD to calendar date, weekday, BCD decode and end time.
module etd_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [39:0]           start_time_code,
  input  logic [23:0]           duration_code,
  output logic                  last_valid,
  output etd_pkg::etd_pipe_t    last
);

  etd_pkg::etd_pipe_t p   [1:etd_pkg::STAGES];
  etd_pkg::etd_pipe_t nxt [1:etd_pkg::STAGES];
  logic [etd_pkg::STAGES:1] v;

  logic [39:0] m_yp;
  logic [22:0] r_yp;
  logic [34:0] m_wq;
  logic [46:0] m_ip;
  logic [36:0] m_mp;
  logic [22:0] r_mp;
  logic [16:0] wd_rem;
  logic [15:0] diff;
  logic [29:0] n_full;
  logic [8:0]  q60a, q60b, q24;
  logic [5:0]  eday_s;
  logic [4:0]  len;
  logic [15:0] day_full;

  always_comb begin
    nxt[1] = '0;
    nxt[1].st_code = start_time_code;
    nxt[1].du_code = duration_code;

    // decode fields, saturate MJD, scale for the year estimate
    nxt[2] = p[1];
    nxt[2].st_undef = (p[1].st_code == etd_pkg::START_UNDEF);
    nxt[2].du_undef = (p[1].du_code == etd_pkg::DUR_UNDEF);
    nxt[2].mjd_raw  = p[1].st_code[39:24];
    nxt[2].mjd      = (p[1].st_code[39:24] < etd_pkg::MJD_MIN) ? etd_pkg::MJD_MIN
                                                               : p[1].st_code[39:24];
    nxt[2].x   = 23'(nxt[2].mjd) * 23'd100 - etd_pkg::X_OFFSET;
    nxt[2].wdv = 17'(p[1].st_code[39:24]) + 17'd2;
    nxt[2].h   = etd_pkg::bcd_byte(p[1].st_code[23:16]);
    nxt[2].m   = etd_pkg::bcd_byte(p[1].st_code[15:8]);
    nxt[2].s   = etd_pkg::bcd_byte(p[1].st_code[7:0]);
    nxt[2].dh  = etd_pkg::bcd_byte(p[1].du_code[23:16]);
    nxt[2].dm  = etd_pkg::bcd_byte(p[1].du_code[15:8]);
    nxt[2].ds  = etd_pkg::bcd_byte(p[1].du_code[7:0]);
    nxt[2].dsec = 20'(nxt[2].dh) * 20'd3600 + 20'(nxt[2].dm) * 20'd60 + 20'(nxt[2].ds);

    // reciprocal estimates
    nxt[3] = p[2];
    m_yp = 40'(p[2].x) * 40'(etd_pkg::YEAR_RECIP);
    nxt[3].yp_est = 8'(m_yp >> 32);
    m_wq = 35'(p[2].wdv) * 35'(etd_pkg::SEVEN_RECIP);
    nxt[3].wq = 14'(m_wq >> 20);
    nxt[3].es_sum = 9'(p[2].s) + 9'(p[2].ds);

    // correct the year estimate, finish weekday, carry seconds
    nxt[4] = p[3];
    r_yp = p[3].x - 23'(p[3].yp_est) * etd_pkg::YEAR_DIV;
    nxt[4].yp = (r_yp >= etd_pkg::YEAR_DIV) ? p[3].yp_est + 8'd1 : p[3].yp_est;
    wd_rem = p[3].wdv - 17'(p[3].wq) * 17'd7;
    nxt[4].week_day = wd_rem[2:0] + 3'd1;
    q60a = etd_pkg::div60(p[3].es_sum);
    nxt[4].cs = q60a[8:6];
    nxt[4].es = q60a[5:0];

    nxt[5] = p[4];
    nxt[5].y = 23'(p[4].yp) * etd_pkg::YEAR_DIV;
    nxt[5].em_sum = 9'(p[4].m) + 9'(p[4].dm) + 9'(p[4].cs);

    nxt[6] = p[5];
    m_ip = 47'(p[5].y) * 47'(etd_pkg::HUND_RECIP);
    nxt[6].ip = 16'(m_ip >> 30);
    q60b = etd_pkg::div60(p[5].em_sum);
    nxt[6].cm = q60b[8:6];
    nxt[6].em = q60b[5:0];

    nxt[7] = p[6];
    diff = p[6].mjd - p[6].ip;
    n_full = 30'(diff) * 30'd10000 - etd_pkg::M_OFFSET;
    nxt[7].n = n_full[22:0];
    nxt[7].eh_sum = 9'(p[6].h) + 9'(p[6].dh) + 9'(p[6].cm);

    nxt[8] = p[7];
    m_mp = 37'(p[7].n) * 37'(etd_pkg::MONTH_RECIP);
    nxt[8].mp_est = 4'(m_mp >> 32);
    q24 = etd_pkg::div24(p[7].eh_sum);
    nxt[8].ch = q24[8:5];
    nxt[8].eh = q24[4:0];

    nxt[9] = p[8];
    r_mp = p[8].n - 23'(p[8].mp_est) * etd_pkg::MONTH_DIV;
    nxt[9].mp = (r_mp >= etd_pkg::MONTH_DIV) ? p[8].mp_est + 4'd1 : p[8].mp_est;

    // day, year and month of the start date
    nxt[10] = p[9];
    day_full = p[9].mjd - etd_pkg::DAY_OFFSET - p[9].ip - 16'(etd_pkg::month_days(p[9].mp));
    nxt[10].day = day_full[4:0];
    if (p[9].mp == 4'd14 || p[9].mp == 4'd15) begin
      nxt[10].year = p[9].yp + 8'd1;
      nxt[10].mon  = p[9].mp - 4'd14;
    end else begin
      nxt[10].year = p[9].yp;
      nxt[10].mon  = p[9].mp - 4'd2;
    end

    // roll the end day into the next month or year
    nxt[11] = p[10];
    eday_s = 6'(p[10].day) + 6'(p[10].ch);
    len = etd_pkg::month_len(p[10].mon, p[10].year);
    if (eday_s > 6'(len)) begin
      nxt[11].eday = 5'(eday_s - 6'(len));
      if (p[10].mon >= 4'd11) begin
        nxt[11].emon  = 4'd0;
        nxt[11].eyear = p[10].year + 8'd1;
      end else begin
        nxt[11].emon  = p[10].mon + 4'd1;
        nxt[11].eyear = p[10].year;
      end
    end else begin
      nxt[11].eday  = eday_s[4:0];
      nxt[11].emon  = p[10].mon;
      nxt[11].eyear = p[10].year;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[etd_pkg::STAGES-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k <= etd_pkg::STAGES; k++) begin
        p[k] <= nxt[k];
      end
    end
  end

  assign last_valid = v[etd_pkg::STAGES];
  assign last       = p[etd_pkg::STAGES];

endmodule

>>> design/event_time_decoder.sv
// An accepted entry moves through the etd_core stage registers; the last stage shows its
// start beat, then its end beat, and the two result beats share one output register.
// The pipeline advances as a whole whenever the last stage is empty or its end beat leaves.
// Reset (rst, synchronous, active high) clears all valid bits and the beat phase;
// payload registers are not reset.
// Each entry yields a start beat (is_end_result 0) then an end beat (is_end_result 1).
module event_time_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [39:0] start_time_code,
  input  logic [23:0] duration_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_end_result,
  output logic [7:0]  year_since_1900,
  output logic [3:0]  month_index,
  output logic [4:0]  day_of_month,
  output logic [2:0]  week_day,
  output logic [7:0]  hour_value,
  output logic [7:0]  minute_value,
  output logic [7:0]  second_value,
  output logic        time_undefined,
  output logic [19:0] duration_seconds
);

  logic               adv;
  logic               last_valid;
  etd_pkg::etd_pipe_t last;
  logic               phase;   // 0: start beat pending, 1: end beat pending

  // advance the pipe when the last stage is empty or its end beat is taken
  assign adv      = !last_valid || (out_ready && phase);
  assign in_ready = adv;

  etd_core u_core (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .in_valid        (in_valid),
    .start_time_code (start_time_code),
    .duration_code   (duration_code),
    .last_valid      (last_valid),
    .last            (last)
  );

  // toggle the beat phase on every accepted output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (out_valid && out_ready) begin
      phase <= !phase;
    end
  end

  assign out_valid        = last_valid;
  assign is_end_result    = phase;
  assign duration_seconds = last.du_undef ? 20'd0 : last.dsec;

  // select start or end fields; drop to zeros when the source is undefined
  always_comb begin
    year_since_1900 = '0;
    month_index     = '0;
    day_of_month    = '0;
    week_day        = '0;
    hour_value      = '0;
    minute_value    = '0;
    second_value    = '0;
    time_undefined  = 1'b1;
    if (!phase) begin
      if (!last.st_undef) begin
        time_undefined  = 1'b0;
        year_since_1900 = last.year;
        month_index     = last.mon;
        day_of_month    = last.day;
        week_day        = last.week_day;
        hour_value      = last.h;
        minute_value    = last.m;
        second_value    = last.s;
      end
    end else begin
      if (!last.st_undef && !last.du_undef) begin
        time_undefined  = 1'b0;
        year_since_1900 = last.eyear;
        month_index     = last.emon;
        day_of_month    = last.eday;
        hour_value      = 8'(last.eh);
        minute_value    = 8'(last.em);
        second_value    = 8'(last.es);
      end
    end
  end

endmodule

>>> design/etd_checker.sv
// Port-level checker for the event time decoder, bound to the top level.
module etd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       is_end_result,
  input logic [2:0] week_day,
  input logic [7:0] hour_value,
  input logic [4:0] day_of_month,
  input logic       time_undefined
);

  // a held beat keeps its kind
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_end_result))
    else $error("output beat changed while stalled");

  // an accepted start beat is followed at once by its end beat
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !is_end_result |=> out_valid && is_end_result)
    else $error("end beat missing after start beat");

  a_wday: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_end_result |-> week_day == 3'd0)
    else $error("weekday set on end beat");

  a_undef: assert property (@(posedge clk) disable iff (rst)
    out_valid && time_undefined |-> hour_value == 8'd0 && day_of_month == 5'd0)
    else $error("undefined beat carries nonzero fields");

endmodule

bind event_time_decoder etd_checker u_etd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .is_end_result  (is_end_result),
  .week_day       (week_day),
  .hour_value     (hour_value),
  .day_of_month   (day_of_month),
  .time_undefined (time_undefined)
);
